// ----- src/lmfe_pkg.sv -----
// Shared constants, command codes and chain-position mapping for the LED matrix frame engine.
// No dependencies.
package lmfe_pkg;

  localparam int SIDE      = 5;
  localparam int LED_TOTAL = SIDE * SIDE;
  localparam int IDX_W     = $clog2(LED_TOTAL);
  localparam int CRD_W     = 3;
  localparam int POS_W     = 6;
  localparam int CMD_W     = 4;
  localparam int CLR_W     = 8;
  localparam int INT_W     = 9;

  localparam logic [CRD_W-1:0] LAST_CRD  = CRD_W'(SIDE - 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LED_TOTAL - 1);
  localparam logic [INT_W-1:0] INT_FULL  = INT_W'(256);

  localparam logic [CMD_W-1:0] CMD_PIXEL   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ROW     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_COLUMN  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_BORDER  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DIAG    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ANTI    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FILL    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 4'd8;

  typedef struct packed {
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] blue;
  } grb_t;

  function automatic logic [IDX_W-1:0] chain_pos(input logic [CRD_W-1:0] x,
                                                 input logic [CRD_W-1:0] y);
    logic [IDX_W-1:0] xx;
    logic [IDX_W-1:0] lin;
    xx  = y[0] ? IDX_W'(LAST_CRD - x) : IDX_W'(x);
    lin = IDX_W'(IDX_W'(y) * IDX_W'(SIDE)) + xx;
    return LAST_IDX - lin;
  endfunction

endpackage

// ----- src/led_matrix_frame_engine_unit.sv -----
// Flow: an accepted command is scaled one colour component at a time on one shared 8x9
// multiplier (S_SCALE), drawn into the pixel store by a walk over every LED (S_DRAW), then
// streamed from the pixel store, one item per cycle with out_ready high (S_STREAM). Set pixel
// skips the stream; in_ready is high only in S_IDLE, so no new command is taken until then.
// Reset: synchronous rst clears the sequencer, the output valid and the pixel store to black.
// Depends on lmfe_pkg.
module led_matrix_frame_engine_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lmfe_pkg::CMD_W-1:0] command,
  input  logic [lmfe_pkg::CRD_W-1:0] x_pos,
  input  logic [lmfe_pkg::CRD_W-1:0] y_pos,
  input  logic [lmfe_pkg::CLR_W-1:0] red,
  input  logic [lmfe_pkg::CLR_W-1:0] green,
  input  logic [lmfe_pkg::CLR_W-1:0] blue,
  input  logic [lmfe_pkg::INT_W-1:0] intensity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lmfe_pkg::POS_W-1:0] led_position,
  output logic [lmfe_pkg::CLR_W-1:0] out_green,
  output logic [lmfe_pkg::CLR_W-1:0] out_red,
  output logic [lmfe_pkg::CLR_W-1:0] out_blue,
  output logic                       frame_end
);
  import lmfe_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCALE  = 2'd1;
  localparam logic [1:0] S_DRAW   = 2'd2;
  localparam logic [1:0] S_STREAM = 2'd3;

  logic [1:0]       state;
  logic [CMD_W-1:0] cmd_q;
  logic [CRD_W-1:0] x_q;
  logic [CRD_W-1:0] y_q;
  logic [CLR_W-1:0] red_q;
  logic [CLR_W-1:0] green_q;
  logic [CLR_W-1:0] blue_q;
  logic [INT_W-1:0] k_q;
  logic [1:0]       comp;
  grb_t             grb_q;
  logic [CRD_W-1:0] x_cnt;
  logic [CRD_W-1:0] y_cnt;
  logic [IDX_W-1:0] stream_idx;
  grb_t             store [LED_TOTAL];

  logic             accept;
  logic             drop;
  logic [CLR_W-1:0] mul_a;
  logic [CLR_W+INT_W-1:0] product;
  logic [CLR_W-1:0] scaled;
  logic             hit;
  logic [CRD_W:0]   diag_sum;
  logic             draw_last;
  logic             load;
  grb_t             wr_value;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign drop     = (command > CMD_REFRESH) ||
                    ((command == CMD_ROW) && (y_pos > LAST_CRD)) ||
                    ((command == CMD_COLUMN) && (x_pos > LAST_CRD));

  always_comb begin
    case (comp)
      2'd0:    mul_a = green_q;
      2'd1:    mul_a = red_q;
      default: mul_a = blue_q;
    endcase
  end

  assign product = (CLR_W+INT_W)'(mul_a) * (CLR_W+INT_W)'(k_q);
  assign scaled  = product[2*CLR_W-1:CLR_W];

  assign diag_sum = (CRD_W+1)'(x_cnt) + (CRD_W+1)'(y_cnt);

  always_comb begin
    case (cmd_q)
      CMD_PIXEL:  hit = (x_cnt == x_q) && (y_cnt == y_q);
      CMD_ROW:    hit = (y_cnt == y_q);
      CMD_COLUMN: hit = (x_cnt == x_q);
      CMD_BORDER: hit = (x_cnt == '0) || (y_cnt == '0) ||
                        (x_cnt == LAST_CRD) || (y_cnt == LAST_CRD);
      CMD_DIAG:   hit = (x_cnt == y_cnt);
      CMD_ANTI:   hit = (diag_sum == (CRD_W+1)'(LAST_CRD));
      CMD_FILL:   hit = 1'b1;
      CMD_CLEAR:  hit = 1'b1;
      default:    hit = 1'b0;
    endcase
  end

  assign wr_value  = (cmd_q == CMD_CLEAR) ? '0 : grb_q;
  assign draw_last = (x_cnt == LAST_CRD) && (y_cnt == LAST_CRD);
  assign load      = (state == S_STREAM) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      x_q     <= x_pos;
      y_q     <= y_pos;
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      k_q     <= (intensity > INT_FULL) ? INT_FULL : intensity;
    end
    if (state == S_SCALE) begin
      case (comp)
        2'd0:    grb_q.green <= scaled;
        2'd1:    grb_q.red   <= scaled;
        default: grb_q.blue  <= scaled;
      endcase
    end
    if (load) begin
      led_position <= POS_W'(stream_idx);
      out_green    <= store[stream_idx].green;
      out_red      <= store[stream_idx].red;
      out_blue     <= store[stream_idx].blue;
      frame_end    <= (stream_idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_TOTAL; i++) begin
        store[i] <= '0;
      end
    end else if ((state == S_DRAW) && hit) begin
      store[chain_pos(x_cnt, y_cnt)] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      comp       <= '0;
      x_cnt      <= '0;
      y_cnt      <= '0;
      stream_idx <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && !drop) begin
            state <= S_SCALE;
            comp  <= '0;
          end
        end
        S_SCALE: begin
          if (comp == 2'd2) begin
            state <= S_DRAW;
            x_cnt <= '0;
            y_cnt <= '0;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_DRAW: begin
          if (x_cnt == LAST_CRD) begin
            x_cnt <= '0;
            y_cnt <= y_cnt + CRD_W'(1);
          end else begin
            x_cnt <= x_cnt + CRD_W'(1);
          end
          if (draw_last) begin
            state      <= (cmd_q == CMD_PIXEL) ? S_IDLE : S_STREAM;
            stream_idx <= '0;
          end
        end
        S_STREAM: begin
          if (load) begin
            if (stream_idx == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              stream_idx <= stream_idx + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (led_position < POS_W'(LED_TOTAL)))
    else $error("led_position beyond the chain");

  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_end == (led_position == POS_W'(LED_TOTAL - 1))))
    else $error("frame_end not on the last LED");

  a_frame_cont: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !frame_end) |-> (state == S_STREAM))
    else $error("frame stopped before its last item");

endmodule

// ----- sim/led_matrix_frame_engine_unit_test.sv -----
// Self-checking testbench for led_matrix_frame_engine_unit: drives drawing commands,
// predicts the streamed LED frames and checks every result item field by field.
// Depends on lmfe_pkg and the led_matrix_frame_engine_unit RTL.
module led_matrix_frame_engine_unit_test;
  import lmfe_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int STALL_CYCLES   = 400;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CLR_W-1:0] r;
    logic [CLR_W-1:0] g;
    logic [CLR_W-1:0] b;
    logic [INT_W-1:0] k;
  } led_cmd_t;

  typedef struct {
    logic [POS_W-1:0] pos;
    logic [CLR_W-1:0] g;
    logic [CLR_W-1:0] r;
    logic [CLR_W-1:0] b;
    logic             last;
  } led_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     command = '0;
  logic [CRD_W-1:0]     x_pos = '0;
  logic [CRD_W-1:0]     y_pos = '0;
  logic [CLR_W-1:0]     red = '0;
  logic [CLR_W-1:0]     green = '0;
  logic [CLR_W-1:0]     blue = '0;
  logic [INT_W-1:0]     intensity = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [POS_W-1:0]     led_position;
  logic [CLR_W-1:0]     out_green;
  logic [CLR_W-1:0]     out_red;
  logic [CLR_W-1:0]     out_blue;
  logic                 frame_end;

  led_cmd_t    cmd_queue[$];
  led_cmd_t    cur_item;
  led_result_t led_expect[$];
  grb_t        frame_px[LED_TOTAL];
  int          items_total = 0;
  int          items_taken = 0;
  int          failures = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          pressure_done = 1'b0;
  int          ready_mode = 0;
  int          mode_left = 0;
  int          phase_cnt = 0;

  led_matrix_frame_engine_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .x_pos(x_pos), .y_pos(y_pos),
    .red(red), .green(green), .blue(blue), .intensity(intensity),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_position(led_position), .out_green(out_green), .out_red(out_red),
    .out_blue(out_blue), .frame_end(frame_end)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int led_slot(int x, int y);
    int xx;
    xx = (y % 2 == 0) ? x : (SIDE - 1 - x);
    return LED_TOTAL - 1 - (y * SIDE + xx);
  endfunction

  function automatic void paint_pixel(int x, int y, grb_t colour);
    if (x < SIDE && y < SIDE) frame_px[led_slot(x, y)] = colour;
  endfunction

  function automatic void apply_command(led_cmd_t c);
    int   k;
    grb_t colour;
    bit   stream;
    led_result_t res;
    k = (c.k > INT_FULL) ? 256 : int'(c.k);
    colour.green = CLR_W'((int'(c.g) * k) >> 8);
    colour.red   = CLR_W'((int'(c.r) * k) >> 8);
    colour.blue  = CLR_W'((int'(c.b) * k) >> 8);
    stream = 1'b1;
    case (c.cmd)
      CMD_PIXEL: begin
        paint_pixel(c.x, c.y, colour);
        stream = 1'b0;
      end
      CMD_ROW: begin
        if (c.y < SIDE) begin
          for (int i = 0; i < SIDE; i++) paint_pixel(i, c.y, colour);
        end else begin
          stream = 1'b0;
        end
      end
      CMD_COLUMN: begin
        if (c.x < SIDE) begin
          for (int i = 0; i < SIDE; i++) paint_pixel(c.x, i, colour);
        end else begin
          stream = 1'b0;
        end
      end
      CMD_BORDER: begin
        for (int j = 0; j < SIDE; j++)
          for (int i = 0; i < SIDE; i++)
            if (i == 0 || j == 0 || i == SIDE - 1 || j == SIDE - 1)
              paint_pixel(i, j, colour);
      end
      CMD_DIAG: begin
        for (int i = 0; i < SIDE; i++) paint_pixel(i, i, colour);
      end
      CMD_ANTI: begin
        for (int i = 0; i < SIDE; i++) paint_pixel(SIDE - 1 - i, i, colour);
      end
      CMD_FILL: begin
        for (int i = 0; i < LED_TOTAL; i++) frame_px[i] = colour;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < LED_TOTAL; i++) frame_px[i] = '0;
      end
      CMD_REFRESH: begin
      end
      default: begin
        stream = 1'b0;
      end
    endcase
    if (stream) begin
      for (int i = 0; i < LED_TOTAL; i++) begin
        res.pos  = POS_W'(i);
        res.g    = frame_px[i].green;
        res.r    = frame_px[i].red;
        res.b    = frame_px[i].blue;
        res.last = (i == LED_TOTAL - 1);
        led_expect.push_back(res);
      end
    end
  endfunction

  function automatic void add_cmd(logic [CMD_W-1:0] cmd, int x, int y,
                                  int r, int g, int b, int k);
    led_cmd_t c;
    c.cmd = cmd;
    c.x   = CRD_W'(x);
    c.y   = CRD_W'(y);
    c.r   = CLR_W'(r);
    c.g   = CLR_W'(g);
    c.b   = CLR_W'(b);
    c.k   = INT_W'(k);
    cmd_queue.push_back(c);
    items_total++;
  endfunction

  function automatic int rand_crd();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, SIDE - 1);
  endfunction

  function automatic int rand_level();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 2) return 256;
    if (sel == 3) return $urandom_range(257, 511);
    if (sel == 4) return 0;
    return $urandom_range(1, 255);
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      failures++;
    end
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      for (int i = 0; i < LED_TOTAL; i++) frame_px[i] = '0;
    end else begin
      if (in_valid && in_ready) begin
        apply_command(cur_item);
        items_taken++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_item = cmd_queue.pop_front();
          command   <= cur_item.cmd;
          x_pos     <= cur_item.x;
          y_pos     <= cur_item.y;
          red       <= cur_item.r;
          green     <= cur_item.g;
          blue      <= cur_item.b;
          intensity <= cur_item.k;
          in_valid  <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 12);
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(5, 60);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check result items and stall the output on a pattern of its own
  always @(posedge clk) begin
    led_result_t exp_res;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (led_expect.size() == 0) begin
          $display("%0t: result with nothing expected, led_position %0d", $time, led_position);
          failures++;
        end else begin
          exp_res = led_expect.pop_front();
          check_field("led_position", exp_res.pos, led_position);
          check_field("out_green", exp_res.g, out_green);
          check_field("out_red", exp_res.r, out_red);
          check_field("out_blue", exp_res.b, out_blue);
          check_field("frame_end", exp_res.last, frame_end);
        end
      end
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!pressure_done && results_seen >= 300) begin
        pressure_done = 1'b1;
        hold_left = STALL_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (phase_cnt % 3) != 0;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int sel;
    int x;
    int y;
    int n;
    logic [CMD_W-1:0] cmd;

    add_cmd(CMD_REFRESH, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_PIXEL, 0, 0, 255, 255, 255, 256);
    add_cmd(CMD_PIXEL, 4, 4, 255, 0, 0, 256);
    add_cmd(CMD_PIXEL, 4, 1, 0, 255, 0, 256);
    add_cmd(CMD_PIXEL, 0, 3, 0, 0, 255, 200);
    add_cmd(CMD_PIXEL, 5, 2, 255, 255, 255, 256);
    add_cmd(CMD_PIXEL, 7, 7, 255, 255, 255, 511);
    add_cmd(CMD_REFRESH, 7, 7, 255, 255, 255, 511);
    add_cmd(CMD_ROW, 0, 0, 255, 128, 1, 300);
    add_cmd(CMD_ROW, 0, 5, 10, 20, 30, 256);
    add_cmd(CMD_ROW, 0, 7, 10, 20, 30, 256);
    add_cmd(CMD_ROW, 3, 1, 200, 100, 50, 129);
    add_cmd(CMD_COLUMN, 4, 0, 255, 255, 255, 0);
    add_cmd(CMD_COLUMN, 6, 0, 255, 255, 255, 256);
    add_cmd(CMD_COLUMN, 1, 6, 77, 88, 99, 256);
    add_cmd(CMD_BORDER, 7, 7, 255, 0, 255, 257);
    add_cmd(CMD_DIAG, 0, 0, 0, 255, 255, 1);
    add_cmd(CMD_ANTI, 0, 0, 170, 85, 255, 256);
    add_cmd(CMD_FILL, 0, 0, 255, 255, 255, 511);
    add_cmd(4'd9, 0, 0, 255, 255, 255, 256);
    add_cmd(4'd15, 7, 7, 255, 255, 255, 511);
    add_cmd(CMD_CLEAR, 3, 3, 255, 255, 255, 256);
    add_cmd(CMD_FILL, 2, 2, 1, 2, 3, 128);
    add_cmd(CMD_REFRESH, 0, 0, 0, 0, 0, 0);

    while (items_total < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      x = rand_crd();
      y = rand_crd();
      if (sel >= 93) begin
        // load a run of pixels, then show the frame
        n = $urandom_range(3, 25);
        for (int i = 0; i < n; i++) begin
          x = rand_crd();
          y = rand_crd();
          add_cmd(CMD_PIXEL, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), rand_level());
        end
        add_cmd(CMD_REFRESH, rand_crd(), rand_crd(), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 511));
      end else begin
        if (sel < 35) cmd = CMD_PIXEL;
        else if (sel < 45) cmd = CMD_REFRESH;
        else if (sel < 55) cmd = CMD_ROW;
        else if (sel < 63) cmd = CMD_COLUMN;
        else if (sel < 68) cmd = CMD_BORDER;
        else if (sel < 73) cmd = CMD_DIAG;
        else if (sel < 78) cmd = CMD_ANTI;
        else if (sel < 84) cmd = CMD_FILL;
        else if (sel < 88) cmd = CMD_CLEAR;
        else cmd = CMD_W'($urandom_range(9, 15));
        add_cmd(cmd, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), rand_level());
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (items_taken < items_total || led_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (led_expect.size() > 0) begin
      $display("%0t: %0d result items never arrived", $time, led_expect.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Test completed with failures");
    $finish;
  end

endmodule
